### src/tqsd_pkg.sv
// tqsd_pkg: shared types and constants for the toml quoted string decoder
// depends on nothing; used by every module of the decoder
`default_nettype none

package tqsd_pkg;

  // decoder phase
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_OPEN1 = 3'd1,
    PH_OPEN2 = 3'd2,
    PH_BODY  = 3'd3,
    PH_ESC   = 3'd4,
    PH_HEX   = 3'd5
  } phase_t;

  // result kinds
  typedef enum logic [1:0] {
    K_CONTENT = 2'd0,
    K_CLOSED  = 2'd1,
    K_ERROR   = 2'd2,
    K_OTHER   = 2'd3
  } kind_t;

  localparam int MaxRes   = 4;
  localparam int ResIdxW  = $clog2(MaxRes);
  localparam int ResCntW  = $clog2(MaxRes + 1);
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_UU     = 8'h55;

  // decoded escape values
  localparam logic [7:0] ESC_BS = 8'h08;
  localparam logic [7:0] ESC_HT = 8'h09;
  localparam logic [7:0] ESC_LF = 8'h0A;
  localparam logic [7:0] ESC_FF = 8'h0C;
  localparam logic [7:0] ESC_CR = 8'h0D;

  // code point limits
  localparam logic [31:0] CP_MAX1    = 32'h0000_007F;
  localparam logic [31:0] CP_MAX2    = 32'h0000_07FF;
  localparam logic [31:0] CP_SUR_LO  = 32'h0000_D800;
  localparam logic [31:0] CP_SUR_HI  = 32'h0000_DFFF;
  localparam logic [31:0] CP_MAX3    = 32'h0000_FFFF;
  localparam logic [31:0] CP_MAX4    = 32'h0010_FFFF;

  // up to four results caused by one input byte
  typedef struct packed {
    logic [ResCntW-1:0]         cnt;
    logic [MaxRes-1:0][1:0]     kinds;
    logic [MaxRes-1:0][7:0]     data;
  } cmd_t;

endpackage

`default_nettype wire

### src/toml_quoted_string_decoder.sv
// toml_quoted_string_decoder: top level of the toml quoted string decoder
// depends on tqsd_pkg, tqsd_front, tqsd_queue, tqsd_back
//
//   channel   signals                       width
//   input     in_valid in_ready in_byte     8
//   output    out_valid out_ready           out_byte 8, kind 2, last 1
//
// the front takes one byte per cycle while the queue has room; each byte
// makes zero to four results that the back sends one per cycle while out_ready
// is high. the first result of a byte is offered the cycle after its transfer
// when the queue was empty. the four-entry queue of result groups lets the
// front keep taking bytes while the back is stalled.
// rst is synchronous and clears phase, queue pointers and output position.
`default_nettype none

module toml_quoted_string_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       kind,
  output logic             last
);

  tqsd_pkg::cmd_t cmd;
  tqsd_pkg::cmd_t head;
  logic           cmd_push;
  logic           q_full;
  logic           q_not_empty;
  logic           q_pop;

  assign in_ready = !q_full;

  // front: byte classification and decoding
  tqsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_valid && in_ready),
    .in_byte  (in_byte),
    .cmd      (cmd),
    .cmd_push (cmd_push)
  );

  // queue of result groups
  tqsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_cmd  (cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // back: result transfers
  tqsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_not_empty),
    .head       (head),
    .head_pop   (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .kind       (kind),
    .last       (last)
  );

endmodule

`default_nettype wire

### src/tqsd_front.sv
// tqsd_front: accepts text bytes, runs the string state machine and builds
// at most one result group per byte; depends on tqsd_pkg
`default_nettype none

module tqsd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_fire,
  input  wire logic [7:0]      in_byte,
  output tqsd_pkg::cmd_t       cmd,
  output logic                 cmd_push
);

  tqsd_pkg::phase_t phase, phase_next;
  logic        is_basic, is_basic_next;
  logic        is_ml, is_ml_next;
  logic [1:0]  pending, pending_next;
  logic [31:0] acc, acc_next;
  logic [3:0]  hex_left, hex_left_next;

  // append one result to a group
  function automatic tqsd_pkg::cmd_t cmd_add(tqsd_pkg::cmd_t c, logic [7:0] d,
                                             tqsd_pkg::kind_t k);
    tqsd_pkg::cmd_t r;
    r = c;
    r.data[c.cnt[tqsd_pkg::ResIdxW-1:0]]  = d;
    r.kinds[c.cnt[tqsd_pkg::ResIdxW-1:0]] = k;
    r.cnt = c.cnt + tqsd_pkg::ResCntW'(1);
    return r;
  endfunction

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= tqsd_pkg::PH_IDLE;
      is_basic <= 1'b0;
      is_ml    <= 1'b0;
      pending  <= 2'd0;
      acc      <= 32'd0;
      hex_left <= 4'd0;
    end else if (in_fire) begin
      phase    <= phase_next;
      is_basic <= is_basic_next;
      is_ml    <= is_ml_next;
      pending  <= pending_next;
      acc      <= acc_next;
      hex_left <= hex_left_next;
    end
  end

  logic [7:0]  c;
  logic [7:0]  q;
  logic        body_go;
  logic        body_ml;
  logic        body_rest;
  logic        go_idle;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [31:0] cp;

  assign c = in_byte;
  assign q = is_basic ? tqsd_pkg::CH_DQUOTE : tqsd_pkg::CH_SQUOTE;

  // hex digit decode
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    case (c) inside
      [8'h30:8'h39]: hex_val = 4'(c - 8'h30);
      [8'h61:8'h66]: hex_val = 4'(c - 8'h57);
      [8'h41:8'h46]: hex_val = 4'(c - 8'h37);
      default:       hex_ok  = 1'b0;
    endcase
  end

  assign cp = {acc[27:0], hex_val};

  // next state and result group
  always_comb begin
    phase_next    = phase;
    is_basic_next = is_basic;
    is_ml_next    = is_ml;
    pending_next  = pending;
    acc_next      = acc;
    hex_left_next = hex_left;
    cmd           = '0;
    body_go       = 1'b0;
    body_ml       = is_ml;
    body_rest     = 1'b0;
    go_idle       = 1'b0;

    case (phase)
      tqsd_pkg::PH_OPEN1: begin
        if (c == q) begin
          phase_next = tqsd_pkg::PH_OPEN2;
        end else begin
          phase_next = tqsd_pkg::PH_BODY;
          is_ml_next = 1'b0;
          body_go    = 1'b1;
          body_ml    = 1'b0;
        end
      end
      tqsd_pkg::PH_OPEN2: begin
        if (c == q) begin
          phase_next   = tqsd_pkg::PH_BODY;
          is_ml_next   = 1'b1;
          pending_next = 2'd0;
        end else begin
          cmd     = cmd_add(cmd, 8'h00, tqsd_pkg::K_CLOSED);
          cmd     = cmd_add(cmd, c, tqsd_pkg::K_OTHER);
          go_idle = 1'b1;
        end
      end
      tqsd_pkg::PH_BODY: begin
        body_go = 1'b1;
      end
      tqsd_pkg::PH_ESC: begin
        phase_next = tqsd_pkg::PH_BODY;
        case (c)
          tqsd_pkg::CH_B:      cmd = cmd_add(cmd, tqsd_pkg::ESC_BS, tqsd_pkg::K_CONTENT);
          tqsd_pkg::CH_T:      cmd = cmd_add(cmd, tqsd_pkg::ESC_HT, tqsd_pkg::K_CONTENT);
          tqsd_pkg::CH_N:      cmd = cmd_add(cmd, tqsd_pkg::ESC_LF, tqsd_pkg::K_CONTENT);
          tqsd_pkg::CH_F:      cmd = cmd_add(cmd, tqsd_pkg::ESC_FF, tqsd_pkg::K_CONTENT);
          tqsd_pkg::CH_R:      cmd = cmd_add(cmd, tqsd_pkg::ESC_CR, tqsd_pkg::K_CONTENT);
          tqsd_pkg::CH_DQUOTE: cmd = cmd_add(cmd, c, tqsd_pkg::K_CONTENT);
          tqsd_pkg::CH_BSLASH: cmd = cmd_add(cmd, c, tqsd_pkg::K_CONTENT);
          tqsd_pkg::CH_LU: begin
            phase_next    = tqsd_pkg::PH_HEX;
            hex_left_next = 4'd4;
            acc_next      = 32'd0;
          end
          tqsd_pkg::CH_UU: begin
            phase_next    = tqsd_pkg::PH_HEX;
            hex_left_next = 4'd8;
            acc_next      = 32'd0;
          end
          default: begin
            cmd     = cmd_add(cmd, 8'h00, tqsd_pkg::K_ERROR);
            go_idle = 1'b1;
          end
        endcase
      end
      tqsd_pkg::PH_HEX: begin
        if (!hex_ok || hex_left == 4'd0) begin
          cmd     = cmd_add(cmd, 8'h00, tqsd_pkg::K_ERROR);
          go_idle = 1'b1;
        end else begin
          acc_next      = cp;
          hex_left_next = hex_left - 4'd1;
          if (hex_left == 4'd1) begin
            phase_next = tqsd_pkg::PH_BODY;
            // utf-8 encode the finished code point; surrogates and values above 10FFFF are errors
            if (cp <= tqsd_pkg::CP_MAX1) begin
              cmd = cmd_add(cmd, cp[7:0], tqsd_pkg::K_CONTENT);
            end else if (cp <= tqsd_pkg::CP_MAX2) begin
              cmd = cmd_add(cmd, {3'b110, cp[10:6]}, tqsd_pkg::K_CONTENT);
              cmd = cmd_add(cmd, {2'b10, cp[5:0]}, tqsd_pkg::K_CONTENT);
            end else if (cp >= tqsd_pkg::CP_SUR_LO && cp <= tqsd_pkg::CP_SUR_HI) begin
              cmd     = cmd_add(cmd, 8'h00, tqsd_pkg::K_ERROR);
              go_idle = 1'b1;
            end else if (cp <= tqsd_pkg::CP_MAX3) begin
              cmd = cmd_add(cmd, {4'b1110, cp[15:12]}, tqsd_pkg::K_CONTENT);
              cmd = cmd_add(cmd, {2'b10, cp[11:6]}, tqsd_pkg::K_CONTENT);
              cmd = cmd_add(cmd, {2'b10, cp[5:0]}, tqsd_pkg::K_CONTENT);
            end else if (cp <= tqsd_pkg::CP_MAX4) begin
              cmd = cmd_add(cmd, {5'b11110, cp[20:18]}, tqsd_pkg::K_CONTENT);
              cmd = cmd_add(cmd, {2'b10, cp[17:12]}, tqsd_pkg::K_CONTENT);
              cmd = cmd_add(cmd, {2'b10, cp[11:6]}, tqsd_pkg::K_CONTENT);
              cmd = cmd_add(cmd, {2'b10, cp[5:0]}, tqsd_pkg::K_CONTENT);
            end else begin
              cmd     = cmd_add(cmd, 8'h00, tqsd_pkg::K_ERROR);
              go_idle = 1'b1;
            end
          end
        end
      end
      default: begin
        // idle: wait for an opening quote; other bytes are handed back as other
        if (c == tqsd_pkg::CH_DQUOTE || c == tqsd_pkg::CH_SQUOTE) begin
          phase_next    = tqsd_pkg::PH_OPEN1;
          is_basic_next = (c == tqsd_pkg::CH_DQUOTE);
          is_ml_next    = 1'b0;
          pending_next  = 2'd0;
          acc_next      = 32'd0;
          hex_left_next = 4'd0;
        end else begin
          cmd     = cmd_add(cmd, c, tqsd_pkg::K_OTHER);
          go_idle = 1'b1;
        end
      end
    endcase

    // string body byte
    if (body_go) begin
      if (body_ml) begin
        if (c == q) begin
          if (pending >= 2'd2) begin
            cmd     = cmd_add(cmd, 8'h00, tqsd_pkg::K_CLOSED);
            go_idle = 1'b1;
          end else begin
            pending_next = pending + 2'd1;
          end
        end else begin
          // release held quotes as content
          if (pending >= 2'd1) cmd = cmd_add(cmd, q, tqsd_pkg::K_CONTENT);
          if (pending >= 2'd2) cmd = cmd_add(cmd, q, tqsd_pkg::K_CONTENT);
          pending_next = 2'd0;
          body_rest    = 1'b1;
        end
      end else begin
        if (c == q) begin
          cmd     = cmd_add(cmd, 8'h00, tqsd_pkg::K_CLOSED);
          go_idle = 1'b1;
        end else if (c == tqsd_pkg::CH_NL) begin
          cmd     = cmd_add(cmd, 8'h00, tqsd_pkg::K_ERROR);
          go_idle = 1'b1;
        end else begin
          body_rest = 1'b1;
        end
      end
      if (body_rest) begin
        if (c == tqsd_pkg::CH_NUL) begin
          cmd     = cmd_add(cmd, 8'h00, tqsd_pkg::K_ERROR);
          go_idle = 1'b1;
        end else if (is_basic && c == tqsd_pkg::CH_BSLASH) begin
          phase_next = tqsd_pkg::PH_ESC;
        end else begin
          cmd = cmd_add(cmd, c, tqsd_pkg::K_CONTENT);
        end
      end
    end

    // early end inside an escape
    if (phase == tqsd_pkg::PH_ESC && c == tqsd_pkg::CH_NUL) begin
      cmd     = '0;
      cmd     = cmd_add(cmd, 8'h00, tqsd_pkg::K_ERROR);
      go_idle = 1'b1;
    end

    // return to idle with state cleared
    if (go_idle) begin
      phase_next    = tqsd_pkg::PH_IDLE;
      is_basic_next = 1'b0;
      is_ml_next    = 1'b0;
      pending_next  = 2'd0;
      acc_next      = 32'd0;
      hex_left_next = 4'd0;
    end
  end

  assign cmd_push = in_fire && (cmd.cnt != '0);

endmodule

`default_nettype wire

### src/tqsd_queue.sv
// tqsd_queue: short queue of result groups between front and back
// depends on tqsd_pkg
`default_nettype none

module tqsd_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire tqsd_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output tqsd_pkg::cmd_t      head
);

  tqsd_pkg::cmd_t                 slots [tqsd_pkg::QDepth];
  logic [tqsd_pkg::QPtrW-1:0]     wr_ptr;
  logic [tqsd_pkg::QPtrW-1:0]     rd_ptr;
  logic [tqsd_pkg::QCntW-1:0]     count;

  assign full      = (count == tqsd_pkg::QCntW'(tqsd_pkg::QDepth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + tqsd_pkg::QPtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + tqsd_pkg::QPtrW'(1);
      if (push && !pop) begin
        count <= count + tqsd_pkg::QCntW'(1);
      end else if (pop && !push) begin
        count <= count - tqsd_pkg::QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/tqsd_back.sv
// tqsd_back: walks the head result group and hands out one result per transfer
// depends on tqsd_pkg
`default_nettype none

module tqsd_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire tqsd_pkg::cmd_t head,
  output logic                head_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic [1:0]          kind,
  output logic                last
);

  logic [tqsd_pkg::ResIdxW-1:0] idx;
  logic                         out_fire;

  assign out_valid = head_valid;
  assign out_fire  = out_valid && out_ready;
  assign out_byte  = head.data[idx];
  assign kind      = head.kinds[idx];
  assign last      = (tqsd_pkg::ResCntW'(idx) + tqsd_pkg::ResCntW'(1) == head.cnt);
  assign head_pop  = out_fire && last;

  // position within the head group
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_fire) begin
      idx <= last ? '0 : idx + tqsd_pkg::ResIdxW'(1);
    end
  end

endmodule

`default_nettype wire

### tb/tb_top.sv
// tb_top: self-checking testbench for toml_quoted_string_decoder
// depends on tqsd_pkg and the decoder rtl; feeds quoted strings, noise and broken text
// byte by byte and checks every decoded result against a built-in decoder model

module tb_top;
  import tqsd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

  localparam int CycleLimit    = 200000;
  localparam int BytesPerPhase = 106;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  // text bytes waiting for the input transfer, and results still owed by the block
  logic [7:0] text_q[$];
  result_t    decoded_q[$];
  result_t    burst[$];
  result_t    want;

  int queued_cnt     = 0;
  int err_cnt        = 0;
  int cycle_cnt      = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit in_fire        = 1'b0;

  // mirror of the decoder state
  phase_t      st_phase;
  logic        st_basic;
  logic        st_multi;
  logic [1:0]  st_pend;
  logic [31:0] st_cp;
  logic [3:0]  st_hex;

  toml_quoted_string_decoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // decoder model
  // ---------------------------------------------------------------------------

  function automatic void put(logic [7:0] b, kind_t k);
    result_t r;
    r.data = b;
    r.kind = k;
    r.last = 1'b0;
    if (burst.size() < MaxRes) burst.push_back(r);
  endfunction

  function automatic void clear_string();
    st_phase = PH_IDLE;
    st_basic = 1'b0;
    st_multi = 1'b0;
    st_pend  = 2'd0;
    st_cp    = 32'd0;
    st_hex   = 4'd0;
  endfunction

  function automatic void flag_error();
    put(CH_NUL, K_ERROR);
    clear_string();
  endfunction

  function automatic logic [7:0] quote_char();
    return st_basic ? CH_DQUOTE : CH_SQUOTE;
  endfunction

  function automatic int hex_value(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // code point to one..four utf-8 bytes; surrogates and out-of-range values fail
  function automatic void put_utf8(logic [31:0] cp);
    if (cp <= CP_MAX1) begin
      put(cp[7:0], K_CONTENT);
    end else if (cp <= CP_MAX2) begin
      put({3'b110, cp[10:6]}, K_CONTENT);
      put({2'b10, cp[5:0]}, K_CONTENT);
    end else if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) begin
      flag_error();
      return;
    end else if (cp <= CP_MAX3) begin
      put({4'b1110, cp[15:12]}, K_CONTENT);
      put({2'b10, cp[11:6]}, K_CONTENT);
      put({2'b10, cp[5:0]}, K_CONTENT);
    end else if (cp <= CP_MAX4) begin
      put({5'b11110, cp[20:18]}, K_CONTENT);
      put({2'b10, cp[17:12]}, K_CONTENT);
      put({2'b10, cp[11:6]}, K_CONTENT);
      put({2'b10, cp[5:0]}, K_CONTENT);
    end else begin
      flag_error();
      return;
    end
    st_phase = PH_BODY;
  endfunction

  function automatic void take_body(logic [7:0] c);
    if (st_multi) begin
      // closing quotes are held until the third one or a different byte
      if (c == quote_char()) begin
        if (st_pend >= 2'd2) begin
          put(CH_NUL, K_CLOSED);
          clear_string();
        end else begin
          st_pend++;
        end
        return;
      end
      while (st_pend > 2'd0) begin
        put(quote_char(), K_CONTENT);
        st_pend--;
      end
    end else begin
      if (c == quote_char()) begin
        put(CH_NUL, K_CLOSED);
        clear_string();
        return;
      end
      if (c == CH_NL) begin
        flag_error();
        return;
      end
    end
    if (c == CH_NUL) begin
      flag_error();
      return;
    end
    if (st_basic && c == CH_BSLASH) begin
      st_phase = PH_ESC;
      return;
    end
    put(c, K_CONTENT);
  endfunction

  function automatic void take_escape(logic [7:0] c);
    st_phase = PH_BODY;
    case (c)
      CH_B:      put(ESC_BS, K_CONTENT);
      CH_T:      put(ESC_HT, K_CONTENT);
      CH_N:      put(ESC_LF, K_CONTENT);
      CH_F:      put(ESC_FF, K_CONTENT);
      CH_R:      put(ESC_CR, K_CONTENT);
      CH_DQUOTE: put(CH_DQUOTE, K_CONTENT);
      CH_BSLASH: put(CH_BSLASH, K_CONTENT);
      CH_LU, CH_UU: begin
        st_phase = PH_HEX;
        st_hex   = (c == CH_LU) ? 4'd4 : 4'd8;
        st_cp    = 32'd0;
      end
      default: flag_error();
    endcase
  endfunction

  function automatic void take_hex(logic [7:0] c);
    int v;
    v = hex_value(c);
    if (v < 0 || st_hex == 4'd0) begin
      flag_error();
      return;
    end
    st_cp = {st_cp[27:0], v[3:0]};
    st_hex--;
    if (st_hex == 4'd0) put_utf8(st_cp);
  endfunction

  // one accepted text byte: compute its results and queue them in order
  function automatic void decode_byte(logic [7:0] c);
    result_t r;
    burst.delete();
    case (st_phase)
      PH_OPEN1: begin
        if (c == quote_char()) begin
          st_phase = PH_OPEN2;
        end else begin
          st_phase = PH_BODY;
          st_multi = 1'b0;
          take_body(c);
        end
      end
      PH_OPEN2: begin
        if (c == quote_char()) begin
          st_phase = PH_BODY;
          st_multi = 1'b1;
          st_pend  = 2'd0;
        end else begin
          put(CH_NUL, K_CLOSED);
          put(c, K_OTHER);
          clear_string();
        end
      end
      PH_BODY: take_body(c);
      PH_ESC: begin
        if (c == CH_NUL) flag_error();
        else take_escape(c);
      end
      PH_HEX: take_hex(c);
      default: begin
        clear_string();
        if (c == CH_DQUOTE || c == CH_SQUOTE) begin
          st_basic = (c == CH_DQUOTE);
          st_phase = PH_OPEN1;
        end else begin
          put(c, K_OTHER);
        end
      end
    endcase
    for (int i = 0; i < burst.size(); i++) begin
      r      = burst[i];
      r.last = (i == burst.size() - 1);
      decoded_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // text generation
  // ---------------------------------------------------------------------------

  function automatic void push(logic [7:0] b);
    text_q.push_back(b);
    queued_cnt++;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return "0" + v;
    return ($urandom_range(1) ? "a" : "A") + v - 4'd10;
  endfunction

  function automatic void push_hex(logic [31:0] cp, int n);
    for (int i = n - 1; i >= 0; i--) push(hex_char(cp[4*i +: 4]));
  endfunction

  // ordinary string byte: never the closing quote, a nul, or a stray backslash in basic
  function automatic logic [7:0] plain_byte(logic basic, logic multi);
    logic [7:0] b;
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) b = $urandom_range(8'h7E, 8'h20);
    else if (sel < 85) b = $urandom_range(8'hFF, 8'h80);
    else b = $urandom_range(8'h1F, 8'h01);
    if (b == (basic ? CH_DQUOTE : CH_SQUOTE) || (basic && b == CH_BSLASH) ||
        (!multi && b == CH_NL))
      b = $urandom_range(8'h7A, 8'h61);
    return b;
  endfunction

  function automatic void push_escape();
    int sel;
    logic [31:0] cp;
    sel = $urandom_range(99);
    push(CH_BSLASH);
    if (sel < 50) begin
      case ($urandom_range(6))
        0: push(CH_B);
        1: push(CH_T);
        2: push(CH_N);
        3: push(CH_F);
        4: push(CH_R);
        5: push(CH_DQUOTE);
        default: push(CH_BSLASH);
      endcase
    end else if (sel < 75) begin
      case ($urandom_range(9))
        0, 1, 2: cp = $urandom_range(32'h7F, 32'h0);
        3, 4, 5: cp = $urandom_range(32'h7FF, 32'h80);
        6, 7, 8: cp = $urandom_range(32'hFFFF, 32'h800);
        default: cp = $urandom_range(CP_SUR_HI, CP_SUR_LO);
      endcase
      push(CH_LU);
      push_hex(cp, 4);
    end else begin
      sel = $urandom_range(19);
      if (sel < 15) cp = $urandom_range(CP_MAX4, 32'h10000);
      else if (sel < 18) cp = $urandom_range(CP_MAX3, 32'h0);
      else cp = $urandom_range(32'hFFFF_FFFF, CP_MAX4 + 1);
      push(CH_UU);
      push_hex(cp, 8);
    end
  endfunction

  function automatic void open_string(logic basic, logic multi);
    logic [7:0] q;
    q = basic ? CH_DQUOTE : CH_SQUOTE;
    push(q);
    if (multi) begin
      push(q);
      push(q);
    end
  endfunction

  function automatic void push_content(logic basic, logic multi, int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (basic && sel < 15) begin
        push_escape();
      end else if (multi && sel >= 85) begin
        // one or two quotes that must come back out as content
        repeat ($urandom_range(2, 1)) push(basic ? CH_DQUOTE : CH_SQUOTE);
        push(plain_byte(basic, multi));
      end else begin
        push(plain_byte(basic, multi));
      end
    end
  endfunction

  function automatic void push_string(logic basic, logic multi);
    open_string(basic, multi);
    push_content(basic, multi, $urandom_range(8, 1));
    open_string(basic, multi);
  endfunction

  // strings cut short or carrying something the decoder must reject
  function automatic void push_broken();
    logic basic;
    logic multi;
    logic [7:0] b;
    int n;
    basic = $urandom_range(1);
    multi = ($urandom_range(3) == 0);
    case ($urandom_range(4))
      0: begin
        open_string(basic, multi);
        push_content(basic, multi, $urandom_range(4, 0));
        if (multi) repeat ($urandom_range(2, 0)) push(basic ? CH_DQUOTE : CH_SQUOTE);
        push(CH_NUL);
      end
      1: begin
        open_string(1'b1, multi);
        push_content(1'b1, multi, $urandom_range(3, 0));
        push(CH_BSLASH);
        b = $urandom_range(255);
        while (b == CH_B || b == CH_T || b == CH_N || b == CH_F || b == CH_R ||
               b == CH_DQUOTE || b == CH_BSLASH || b == CH_LU || b == CH_UU)
          b = $urandom_range(255);
        push(b);
      end
      2: begin
        open_string(1'b1, multi);
        push_content(1'b1, multi, $urandom_range(3, 0));
        push(CH_BSLASH);
        n = $urandom_range(1) ? 4 : 8;
        push(n == 4 ? CH_LU : CH_UU);
        repeat ($urandom_range(n - 1, 0)) push(hex_char($urandom_range(15)));
        b = $urandom_range(255);
        while (hex_value(b) >= 0) b = $urandom_range(255);
        push(b);
      end
      3: begin
        open_string(basic, 1'b0);
        push_content(basic, 1'b0, $urandom_range(4, 0));
        push(CH_NL);
      end
      default: begin
        open_string(1'b1, multi);
        push(CH_BSLASH);
        if ($urandom_range(1)) begin
          push(CH_LU);
          push_hex($urandom_range(CP_SUR_HI, CP_SUR_LO), 4);
        end else begin
          push(CH_UU);
          push_hex($urandom_range(32'hFFFF_FFFF, CP_MAX4 + 1), 8);
        end
      end
    endcase
  endfunction

  function automatic void load_random(int target);
    int start;
    int sel;
    logic [7:0] q;
    logic [7:0] b;
    start = queued_cnt;
    while (queued_cnt - start < target) begin
      sel = $urandom_range(99);
      if (sel < 25) begin
        push_string(1'b1, 1'b0);
      end else if (sel < 40) begin
        push_string(1'b0, 1'b0);
      end else if (sel < 55) begin
        push_string(1'b1, 1'b1);
      end else if (sel < 65) begin
        push_string(1'b0, 1'b1);
      end else if (sel < 70) begin
        // empty string: the byte after the quote pair is handed back
        q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
        push(q);
        push(q);
        b = $urandom_range(255);
        while (b == q) b = $urandom_range(255);
        push(b);
      end else if (sel < 80) begin
        // bytes between strings, now and then a nul among them
        repeat ($urandom_range(3, 1)) begin
          b = ($urandom_range(9) == 0) ? CH_NUL : $urandom_range(255);
          while (b == CH_DQUOTE || b == CH_SQUOTE) b = $urandom_range(255);
          push(b);
        end
      end else begin
        push_broken();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver, monitor and run control
  // ---------------------------------------------------------------------------

  // drive on the falling edge; valid holds with its byte until the transfer
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_byte  <= text_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // sample on the rising edge: model input transfers first, then check outputs
  always @(posedge clk) begin
    in_fire = 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        decode_byte(in_byte);
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result: expected none, actual byte %02h kind %0d last %0d",
                   $time, out_byte, kind, last);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data) begin
            err_cnt++;
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte);
          end
          if (kind !== want.kind) begin
            err_cnt++;
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
          end
          if (last !== want.last) begin
            err_cnt++;
            $display("%0t: last expected %0d actual %0d", $time, want.last, last);
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    clear_string();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idling phases: none, sender gaps, receiver stalls, both lightly
    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      send_idle_pct  = (ph == 1) ? 60 : (ph == 3) ? 8 : 0;
      recv_stall_pct = (ph == 2) ? 60 : (ph == 3) ? 8 : 0;
      if (ph == 0) begin
        // nul and top byte outside a string, bare quote pair
        push(CH_NUL);
        push(8'hFF);
        push(CH_DQUOTE); push(CH_DQUOTE); push("x");
        // newline escape and a two-byte hex escape
        push(CH_DQUOTE); push(CH_BSLASH); push(CH_N);
        push(CH_BSLASH); push(CH_LU); push("0"); push("0"); push("e"); push("9");
        push(CH_DQUOTE);
        // early end, newline in a single-line literal
        push(CH_DQUOTE); push(CH_NUL);
        push(CH_SQUOTE); push(CH_NL);
        // held quotes released ahead of an early-end error
        push(CH_DQUOTE); push(CH_DQUOTE); push(CH_DQUOTE); push("q");
        push(CH_DQUOTE); push(CH_DQUOTE); push(CH_NUL);
      end
      load_random(BytesPerPhase);
      while (text_q.size() != 0) @(negedge clk);
    end

    while (in_valid || decoded_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (err_cnt == 0 && decoded_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
